/* sv/mmba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmba_pkg
// Shared types and constants for the memory map bump allocator.
// ----------------------------------------------------------------------------
package mmba_pkg;

   localparam int MAP_DEPTH_DEFAULT = 16;

   localparam logic [7:0]  SIZE_CODE_OK = 8'd20;
   localparam logic [31:0] TYPE_AVAIL_RAM = 32'd1;
   localparam logic [31:0] TYPE_AVAIL_ACPI = 32'd3;

   localparam logic [1:0] CSR_START_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_MAP_BYTES = 2'd1;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_ALLOC = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC,
      ST_SEEK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      ADDR_ZERO,
      ADDR_NEXT_FREE,
      ADDR_BASE
   } addr_sel_type;

   typedef struct packed {
      logic [7:0]  size_code;
      logic [63:0] base;
      logic [63:0] length;
      logic [31:0] kind;
   } map_entry_type;

   typedef struct packed {
      logic         write_entry;
      logic         init_start;
      logic         latch_request;
      logic         step;
      logic         bump;
      logic         grant_new;
      logic         set_usable;
      logic         clear_usable;
      logic         finish;
      logic         fin_status;
      addr_sel_type fin_addr;
      logic         rsp_push;
   } ctrl_cmd_type;

   typedef struct packed {
      logic usable;
      logic cursor_end;
      logic budget_zero;
      logic code_ok;
      logic avail;
      logic contains;
      logic fits_cur;
      logic fits_new;
      logic rsp_busy;
   } dp_status_type;

endpackage
`default_nettype wire

/* sv/mmba_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmba_ctrl
// Command sequencer: decodes an item and steps the datapath through scans.
// ----------------------------------------------------------------------------
module mmba_ctrl
   import mmba_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic [1:0]    req_command,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.fin_addr = ADDR_ZERO;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_request = 1'b1;
               case (cmd_type'(req_command))
                  CMD_LOAD: begin
                     cmd.write_entry = 1'b1;
                     cmd.finish = 1'b1;
                     state_in = ST_DONE;
                  end
                  CMD_START: begin
                     cmd.init_start = 1'b1;
                     state_in = ST_SCAN;
                  end
                  CMD_ALLOC: begin
                     state_in = ST_ALLOC;
                  end
                  default: begin
                     cmd.finish = 1'b1;
                     cmd.fin_status = 1'b1;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (status.budget_zero || status.cursor_end || !status.code_ok) begin
               cmd.finish = 1'b1;
               cmd.fin_status = 1'b1;
               state_in = ST_DONE;
            end else if (status.avail && status.contains) begin
               cmd.set_usable = 1'b1;
               cmd.finish = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_ALLOC: begin
            if (!status.usable || status.cursor_end) begin
               cmd.clear_usable = 1'b1;
               cmd.finish = 1'b1;
               cmd.fin_status = 1'b1;
               state_in = ST_DONE;
            end else if (status.fits_cur) begin
               cmd.bump = 1'b1;
               cmd.finish = 1'b1;
               cmd.fin_addr = ADDR_NEXT_FREE;
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_SEEK;
            end
         end
         ST_SEEK: begin
            if (status.budget_zero || status.cursor_end || !status.code_ok) begin
               cmd.clear_usable = 1'b1;
               cmd.finish = 1'b1;
               cmd.fin_status = 1'b1;
               state_in = ST_DONE;
            end else if (status.avail && status.fits_new) begin
               cmd.grant_new = 1'b1;
               cmd.finish = 1'b1;
               cmd.fin_addr = ADDR_BASE;
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               cmd.rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* sv/mmba_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmba_datapath
// Map table, allocator registers, fit compares and the result register.
// ----------------------------------------------------------------------------
module mmba_datapath
   import mmba_pkg::*;
#(
   parameter int MAP_DEPTH = MAP_DEPTH_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_valid,
   input  wire logic [1:0]    csr_index,
   input  wire logic [63:0]   csr_data,
   input  wire logic [3:0]    req_entry_index,
   input  wire logic [7:0]    req_size_code,
   input  wire logic [63:0]   req_entry_base,
   input  wire logic [63:0]   req_entry_length,
   input  wire logic [31:0]   req_entry_type,
   input  wire logic [63:0]   req_request_size,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_status,
   output logic [63:0]        rsp_address,
   input  wire ctrl_cmd_type  cmd,
   output dp_status_type      status
);

   localparam int IDX_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int CUR_W = $clog2(MAP_DEPTH + 1);

   map_entry_type       mem [MAP_DEPTH];
   map_entry_type       rd_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;
   logic                wr_in_range;
   map_entry_type       wr_entry;

   logic [63:0]         start_address_ff;
   logic [15:0]         map_bytes_ff;
   logic [CUR_W-1:0]    cursor_ff;
   logic [CUR_W-1:0]    cursor_in;
   logic [15:0]         budget_ff;
   logic [15:0]         budget_in;
   logic [15:0]         spend_code;
   logic [63:0]         next_free_ff;
   logic [63:0]         next_free_in;
   logic                usable_ff;
   logic                usable_in;
   logic [63:0]         request_ff;

   logic                pend_status_ff;
   logic [63:0]         pend_addr_ff;
   logic [63:0]         pend_addr_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_status_ff;
   logic [63:0]         rsp_address_ff;

   logic [64:0]         end65;
   logic [64:0]         bump65;
   logic [64:0]         new65;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         start_address_ff <= '0;
         map_bytes_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_START_ADDRESS) begin
            start_address_ff <= csr_data;
         end else if (csr_index == CSR_MAP_BYTES) begin
            map_bytes_ff <= csr_data[15:0];
         end
      end
   end

   // map table
   assign wr_in_range = (32'(req_entry_index) < MAP_DEPTH);
   assign wr_addr = IDX_W'(req_entry_index);
   assign wr_entry = '{size_code: req_size_code, base: req_entry_base,
                       length: req_entry_length, kind: req_entry_type};
   assign rd_addr = (32'(cursor_in) < MAP_DEPTH) ? cursor_in[IDX_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (cmd.write_entry && wr_in_range) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_ff <= mem[rd_addr];
   end

   // compares on the entry at the cursor
   assign end65  = {1'b0, rd_ff.base} + {1'b0, rd_ff.length};
   assign bump65 = {1'b0, next_free_ff} + {1'b0, request_ff};
   assign new65  = {1'b0, rd_ff.base} + {1'b0, request_ff};

   assign status.usable      = usable_ff;
   assign status.cursor_end  = (32'(cursor_ff) >= MAP_DEPTH);
   assign status.budget_zero = (budget_ff == '0);
   assign status.code_ok     = (rd_ff.size_code == SIZE_CODE_OK);
   assign status.avail       = (rd_ff.kind == TYPE_AVAIL_RAM) ||
                               (rd_ff.kind == TYPE_AVAIL_ACPI);
   assign status.contains    = (rd_ff.base <= next_free_ff) &&
                               ({1'b0, next_free_ff} <= end65);
   assign status.fits_cur    = !bump65[64] && (bump65 <= end65);
   assign status.fits_new    = (rd_ff.length >= request_ff) && !new65[64];
   assign status.rsp_busy    = rsp_valid_ff && !rsp_ready;

   // allocator state
   assign spend_code = {8'd0, rd_ff.size_code};

   always_comb begin
      cursor_in = cursor_ff;
      budget_in = budget_ff;
      next_free_in = next_free_ff;
      usable_in = usable_ff;
      if (cmd.init_start) begin
         cursor_in = '0;
         budget_in = map_bytes_ff;
         next_free_in = start_address_ff;
         usable_in = 1'b0;
      end
      if (cmd.step) begin
         cursor_in = cursor_ff + CUR_W'(1);
         budget_in = (budget_ff > spend_code) ? (budget_ff - spend_code) : '0;
      end
      if (cmd.bump) begin
         next_free_in = bump65[63:0];
      end
      if (cmd.grant_new) begin
         next_free_in = new65[63:0];
      end
      if (cmd.set_usable) begin
         usable_in = 1'b1;
      end
      if (cmd.clear_usable) begin
         usable_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         budget_ff <= '0;
         next_free_ff <= '0;
         usable_ff <= 1'b0;
      end else begin
         cursor_ff <= cursor_in;
         budget_ff <= budget_in;
         next_free_ff <= next_free_in;
         usable_ff <= usable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_request) begin
         request_ff <= req_request_size;
      end
   end

   // pending and output result
   always_comb begin
      case (cmd.fin_addr)
         ADDR_NEXT_FREE: pend_addr_in = next_free_ff;
         ADDR_BASE:      pend_addr_in = rd_ff.base;
         default:        pend_addr_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         pend_status_ff <= cmd.fin_status;
         pend_addr_ff <= pend_addr_in;
      end
      if (cmd.rsp_push) begin
         rsp_status_ff <= pend_status_ff;
         rsp_address_ff <= pend_addr_ff;
      end
   end

   assign rsp_valid_in = cmd.rsp_push ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_address = rsp_address_ff;

endmodule
`default_nettype wire

/* sv/memory_map_bump_allocator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// memory_map_bump_allocator_top
// Bump allocator over a loaded boot memory map.
//
// Items enter on req_* (valid/ready) and each yields one item on rsp_*.
// Command 0 loads a map entry, 1 searches from entry 0 for the available
// block holding the start address, 2 allocates request_size bytes.
// Registers start_address and map_bytes are written on csr_* (always ready).
// Load and unknown commands finish on accept and pass through the done state to
// the output register; an allocate that fits the current block first passes the
// allocate state. Start and walking allocates examine up to MAP_DEPTH map entries
// one at a time, paced by the single registered read port of the map table.
// A new item is accepted once the previous one has reached the output
// register; the result waits there while rsp_ready is low, and a further
// finished result waits inside until the register frees.
// Reset clears the allocator (invalid until started), the registers and the
// output valid; table entries are undefined until loaded.
// ----------------------------------------------------------------------------
module memory_map_bump_allocator_top
   import mmba_pkg::*;
#(
   parameter int MAP_DEPTH = MAP_DEPTH_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [63:0]   csr_data,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [1:0]    req_command,
   input  wire logic [3:0]    req_entry_index,
   input  wire logic [7:0]    req_size_code,
   input  wire logic [63:0]   req_entry_base,
   input  wire logic [63:0]   req_entry_length,
   input  wire logic [31:0]   req_entry_type,
   input  wire logic [63:0]   req_request_size,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_status,
   output logic [63:0]        rsp_address
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   mmba_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   mmba_datapath #(
      .MAP_DEPTH (MAP_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_entry_index  (req_entry_index),
      .req_size_code    (req_size_code),
      .req_entry_base   (req_entry_base),
      .req_entry_length (req_entry_length),
      .req_entry_type   (req_entry_type),
      .req_request_size (req_request_size),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_address      (rsp_address),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
`default_nettype wire

/* tb/memory_map_bump_allocator_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_map_bump_allocator_top_tb
// Self-checking bench for the memory map bump allocator. Each phase loads a
// fresh map, programs the start address and map length, then runs mostly
// allocates with some starts, table edits and unknown commands. An in-bench
// allocator model predicts status and address for every accepted item.
// Random stalls on both channels, a long result hold-off and a drain pause
// exercise backpressure.
// ----------------------------------------------------------------------------
module memory_map_bump_allocator_top_tb
   import mmba_pkg::*;
();

   localparam int DEPTH = MAP_DEPTH_DEFAULT;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam logic [31:0] TYPE_RESERVED = 32'd2;
   localparam int NUM_PHASES = 14;
   localparam int PHASE_ITEMS = 108;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [1:0]  command;
      logic [3:0]  entry_index;
      logic [7:0]  size_code;
      logic [63:0] entry_base;
      logic [63:0] entry_length;
      logic [31:0] entry_type;
      logic [63:0] request_size;
   } alloc_req_type;

   typedef struct {
      logic        status;
      logic [63:0] address;
   } grant_type;

   class alloc_scoreboard_type;
      logic [7:0]  size_code[DEPTH];
      logic [63:0] base[DEPTH];
      logic [63:0] length[DEPTH];
      logic [31:0] kind[DEPTH];
      int          cursor;
      logic [15:0] budget;
      logic [63:0] next_free;
      bit          usable;
      logic [63:0] start_address;
      logic [15:0] map_bytes;
      grant_type   pending[$];
      int          errors;
      int          checked;

      function new();
         cursor = 0;
         budget = '0;
         next_free = '0;
         usable = 0;
         start_address = '0;
         map_bytes = '0;
         errors = 0;
         checked = 0;
      endfunction

      task report(string what);
         errors++;
         $display("ERROR result %0d at %0t: %s", checked, $realtime, what);
      endtask

      function void set_register(logic [1:0] idx, logic [63:0] data);
         if (idx == CSR_START_ADDRESS) start_address = data;
         else if (idx == CSR_MAP_BYTES) map_bytes = data[15:0];
      endfunction

      function bit is_available(logic [31:0] t);
         return t == TYPE_AVAIL_RAM || t == TYPE_AVAIL_ACPI;
      endfunction

      function void spend(logic [7:0] code);
         budget = (budget > {8'h0, code}) ? budget - {8'h0, code} : 16'h0;
      endfunction

      // step past the current region, then find the next available one
      function bit advance_region();
         if (cursor < DEPTH) spend(size_code[cursor]);
         cursor++;
         while (budget > 0) begin
            if (cursor >= DEPTH) break;
            if (size_code[cursor] != SIZE_CODE_OK) break;
            if (is_available(kind[cursor])) return 1;
            spend(size_code[cursor]);
            cursor++;
         end
         usable = 0;
         return 0;
      endfunction

      function bit start_search();
         logic [64:0] region_end;
         usable = 0;
         next_free = start_address;
         budget = map_bytes;
         cursor = 0;
         while (budget > 0 && cursor < DEPTH) begin
            if (size_code[cursor] != SIZE_CODE_OK) return 0;
            region_end = {1'b0, base[cursor]} + {1'b0, length[cursor]};
            if (base[cursor] <= next_free && {1'b0, next_free} <= region_end &&
                is_available(kind[cursor])) begin
               usable = 1;
               return 1;
            end
            spend(size_code[cursor]);
            cursor++;
         end
         return 0;
      endfunction

      function bit allocate(logic [63:0] req, output logic [63:0] addr);
         logic [64:0] region_end;
         logic [64:0] bumped;
         addr = '0;
         if (!usable || cursor >= DEPTH) begin
            usable = 0;
            return 0;
         end
         region_end = {1'b0, base[cursor]} + {1'b0, length[cursor]};
         bumped = {1'b0, next_free} + {1'b0, req};
         if (!bumped[64] && bumped <= region_end) begin
            addr = next_free;
            next_free = bumped[63:0];
            return 1;
         end
         while (advance_region()) begin
            bumped = {1'b0, base[cursor]} + {1'b0, req};
            if (length[cursor] >= req && !bumped[64]) begin
               next_free = bumped[63:0];
               addr = base[cursor];
               return 1;
            end
         end
         return 0;
      endfunction

      function void note_request(alloc_req_type it);
         grant_type   g;
         logic [63:0] a;
         g.status = 1'b0;
         g.address = '0;
         case (it.command)
            CMD_LOAD: begin
               if (int'(it.entry_index) < DEPTH) begin
                  size_code[it.entry_index] = it.size_code;
                  base[it.entry_index] = it.entry_base;
                  length[it.entry_index] = it.entry_length;
                  kind[it.entry_index] = it.entry_type;
               end
            end
            CMD_START: g.status = !start_search();
            CMD_ALLOC: begin
               if (allocate(it.request_size, a)) g.address = a;
               else g.status = 1'b1;
            end
            default: g.status = 1'b1;
         endcase
         pending.push_back(g);
      endfunction

      task check_response(logic status, logic [63:0] address);
         grant_type want;
         checked++;
         if (pending.size() == 0) begin
            report("result with no item outstanding");
            return;
         end
         want = pending.pop_front();
         if (status !== want.status)
            report($sformatf("status %b, expected %b", status, want.status));
         if (address !== want.address)
            report($sformatf("address %h, expected %h", address, want.address));
      endtask
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = '0;
   logic [3:0]  req_entry_index = '0;
   logic [7:0]  req_size_code = '0;
   logic [63:0] req_entry_base = '0;
   logic [63:0] req_entry_length = '0;
   logic [31:0] req_entry_type = '0;
   logic [63:0] req_request_size = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [63:0] rsp_address;

   alloc_scoreboard_type sb = new();

   int          send_idle = 30;
   int          rcv_idle = 51;
   int          hold_len = 0;
   logic [63:0] map_base[DEPTH];
   logic [63:0] map_len[DEPTH];
   bit          map_avail[DEPTH];

   memory_map_bump_allocator_top #(
      .MAP_DEPTH(DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_entry_index(req_entry_index),
      .req_size_code(req_size_code),
      .req_entry_base(req_entry_base),
      .req_entry_length(req_entry_length),
      .req_entry_type(req_entry_type),
      .req_request_size(req_request_size),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_address(rsp_address)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // result side: random stalls plus an occasional long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
         end
         rsp_ready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_status, rsp_address);
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic alloc_req_type make_item(logic [1:0] cmd, logic [3:0] idx,
                                               logic [7:0] size, logic [63:0] b,
                                               logic [63:0] len, logic [31:0] kind,
                                               logic [63:0] req);
      alloc_req_type it;
      it.command = cmd;
      it.entry_index = idx;
      it.size_code = size;
      it.entry_base = b;
      it.entry_length = len;
      it.entry_type = kind;
      it.request_size = req;
      return it;
   endfunction

   function automatic logic [31:0] avail_type();
      return $urandom_range(1) ? TYPE_AVAIL_RAM : TYPE_AVAIL_ACPI;
   endfunction

   function automatic alloc_req_type random_item();
      alloc_req_type it;
      int            pick;
      int            r;
      it = make_item(CMD_ALLOC, 4'($urandom), 8'($urandom), rand64(), rand64(),
                     $urandom, rand64());
      pick = $urandom_range(99);
      if (pick < 6) begin
         it.command = CMD_LOAD;
         if ($urandom_range(9) != 0) begin
            it.size_code = SIZE_CODE_OK;
            it.entry_base = map_base[it.entry_index];
            it.entry_length = 64'($urandom_range(0, 4096));
            it.entry_type = avail_type();
         end
      end else if (pick < 14) begin
         it.command = CMD_START;
      end else if (pick < 16) begin
         it.command = CMD_UNKNOWN;
      end else begin
         r = $urandom_range(99);
         if (r < 60) it.request_size = 64'($urandom_range(0, 512));
         else if (r < 70) it.request_size = '0;
         else if (r < 82) it.request_size = 64'($urandom_range(513, 8192));
         else if (r < 91) it.request_size = rand64();
         else it.request_size = ALL_ONES - 64'($urandom_range(0, 4096));
      end
      return it;
   endfunction

   function automatic logic [63:0] start_for_phase(int phase);
      int j;
      if (phase == 3 || phase == 10) return ALL_ONES;
      if (phase == 6) return '0;
      j = $urandom_range(0, 7);
      for (int n = 0; n < DEPTH && !map_avail[j]; n++) j = (j + 1) % DEPTH;
      case ($urandom_range(3))
         0: return map_base[j];
         1: return map_base[j] + map_len[j];
         default: return map_base[j] + (map_len[j] >> $urandom_range(1, 16));
      endcase
   endfunction

   function automatic logic [15:0] bytes_for_phase(int phase);
      case (phase)
         1: return 16'd0;
         2, 8: return 16'hFFFF;
         4: return 16'(SIZE_CODE_OK);
         5: return 16'(SIZE_CODE_OK) - 16'd1;
         default: begin
            if (phase % 3 == 0) return 16'($urandom);
            return 16'(SIZE_CODE_OK) * 16'($urandom_range(2, DEPTH));
         end
      endcase
   endfunction

   task automatic send_item(input alloc_req_type it);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= it.command;
      req_entry_index <= it.entry_index;
      req_size_code <= it.size_code;
      req_entry_base <= it.entry_base;
      req_entry_length <= it.entry_length;
      req_entry_type <= it.entry_type;
      req_request_size <= it.request_size;
      do @(posedge clock); while (!req_ready);
      sb.note_request(it);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic program_registers(input logic [63:0] start, input logic [15:0] bytes);
      csr_valid <= 1'b1;
      csr_index <= CSR_START_ADDRESS;
      csr_data <= start;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_START_ADDRESS, start);
      csr_index <= CSR_MAP_BYTES;
      csr_data <= {$urandom, 16'($urandom), bytes};
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_MAP_BYTES, {48'h0, bytes});
      csr_valid <= 1'b0;
   endtask

   // fresh map: mostly valid ascending regions, some reserved or broken
   task automatic load_map(input int phase);
      logic [63:0] addr;
      logic [63:0] len;
      logic [31:0] kind;
      logic [7:0]  size;
      int          r;
      if (phase == 3 || phase == 10) addr = ALL_ONES - 64'($urandom_range(0, 20000));
      else if (phase == 6) addr = '0;
      else addr = {16'h0, $urandom, 16'h0};
      for (int k = 0; k < DEPTH; k++) begin
         r = $urandom_range(39);
         size = (r == 0) ? 8'd0 : (r == 1) ? 8'($urandom) : SIZE_CODE_OK;
         r = $urandom_range(9);
         if (r < 7) kind = avail_type();
         else if (r < 8) kind = TYPE_RESERVED;
         else kind = $urandom;
         r = $urandom_range(29);
         if (r == 0) len = '0;
         else if (r == 1) len = rand64();
         else len = 64'($urandom_range(16, 4096));
         map_base[k] = addr;
         map_len[k] = len;
         map_avail[k] = (kind == TYPE_AVAIL_RAM || kind == TYPE_AVAIL_ACPI);
         send_item(make_item(CMD_LOAD, 4'(k), size, addr, len, kind, rand64()));
         addr = addr + len + 64'($urandom_range(0, 256));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: hand-built map, then fits, exact fit, walks, overflow, failure
      program_registers(64'h1000, 16'hFFFF);
      send_item(make_item(CMD_LOAD, 4'd0, SIZE_CODE_OK, 64'h0, 64'h1000,
                          TYPE_RESERVED, '0));
      send_item(make_item(CMD_LOAD, 4'd1, SIZE_CODE_OK, 64'h1000, 64'h1000,
                          TYPE_AVAIL_RAM, '0));
      send_item(make_item(CMD_LOAD, 4'd2, SIZE_CODE_OK, 64'h3000, 64'h100,
                          TYPE_AVAIL_ACPI, '0));
      send_item(make_item(CMD_LOAD, 4'd3, SIZE_CODE_OK, 64'h4000, 64'h1000,
                          32'hFFFF_FFFF, '0));
      send_item(make_item(CMD_LOAD, 4'd4, SIZE_CODE_OK, 64'hFFFF_FFFF_FFFF_F000,
                          64'h2000, TYPE_AVAIL_RAM, '0));
      send_item(make_item(CMD_LOAD, 4'd5, 8'd0, 64'h5000, 64'h1000,
                          TYPE_AVAIL_RAM, '0));
      send_item(make_item(CMD_LOAD, 4'd6, 8'd24, ALL_ONES, ALL_ONES,
                          TYPE_AVAIL_ACPI, '0));
      for (int k = 7; k < DEPTH - 1; k++)
         send_item(make_item(CMD_LOAD, 4'(k), SIZE_CODE_OK, 64'(k) << 16, 64'h800,
                             TYPE_AVAIL_RAM, '0));
      send_item(make_item(CMD_LOAD, 4'(DEPTH - 1), 8'hFF, ALL_ONES, ALL_ONES,
                          32'hFFFF_FFFF, ALL_ONES));
      send_item(make_item(CMD_START, '0, '0, '0, '0, '0, '0));
      send_item(make_item(CMD_ALLOC, '0, '0, '0, '0, '0, 64'h800));
      send_item(make_item(CMD_ALLOC, '0, '0, '0, '0, '0, 64'h800));
      send_item(make_item(CMD_ALLOC, '0, '0, '0, '0, '0, 64'h10));
      send_item(make_item(CMD_ALLOC, '0, '0, '0, '0, '0, 64'h200));
      send_item(make_item(CMD_ALLOC, '0, '0, '0, '0, '0, 64'h1000));
      send_item(make_item(CMD_ALLOC, '0, '0, '0, '0, '0, '0));
      send_item(make_item(CMD_UNKNOWN, '0, '0, '0, '0, '0, '0));
      drain();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase < 5) begin
            send_idle = 30;
            rcv_idle = 51;
         end else if (phase < 10) begin
            send_idle = 51;
            rcv_idle = 30;
         end else begin
            send_idle = 0;
            rcv_idle = 0;
         end
         load_map(phase);
         drain();
         program_registers(start_for_phase(phase), bytes_for_phase(phase));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 2 && n == 40) hold_len = HOLD_CYCLES;
            if (phase == 7 && n == 50) drain();
            send_item(random_item());
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* memory_map_bump_allocator_top.f */
sv/mmba_pkg.sv
sv/mmba_ctrl.sv
sv/mmba_datapath.sv
sv/memory_map_bump_allocator_top.sv
tb/memory_map_bump_allocator_top_tb.sv
